### hdl/assert_macros.svh
// Assertion macros used by the top level of the normalizer.
// No dependencies; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define U8WS_AST_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("normalizer assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define U8WS_AST_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("normalizer assertion failed");

`endif

### hdl/u8ws_pkg.sv
// Types, character constants and decode helpers for the UTF-8 fold and
// trailing whitespace normalizer. No dependencies.
package u8ws_pkg;

    // Operation passed from the decoder to the strip stage.
    typedef struct packed {
        logic [7:0] data;
        logic       last;   // last operation caused by one input beat
        logic       eot;    // that input beat ends the text
    } t_op;

    // One result beat.
    typedef struct packed {
        logic [7:0] data;
        logic       vld;    // 0 for an end marker
        logic       last;
        logic       done;
        logic       ovf;
    } t_res;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_VT      = 8'h0B;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_QUOTE   = 8'h27;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_HYPHEN  = 8'h2D;

    // Whitespace codes kept in the hold store.
    localparam logic [2:0] WS_SPACE = 3'd0;
    localparam logic [2:0] WS_TAB   = 3'd1;
    localparam logic [2:0] WS_CR    = 3'd2;
    localparam logic [2:0] WS_FF    = 3'd3;
    localparam logic [2:0] WS_VT    = 3'd4;

    // Code points of the fold table.
    localparam logic [20:0] CP_SQ_LO    = 21'h02018;
    localparam logic [20:0] CP_SQ_HI    = 21'h0201B;
    localparam logic [20:0] CP_DQ_LO    = 21'h0201C;
    localparam logic [20:0] CP_DQ_HI    = 21'h0201F;
    localparam logic [20:0] CP_DASH_LO  = 21'h02010;
    localparam logic [20:0] CP_DASH_HI  = 21'h02015;
    localparam logic [20:0] CP_MINUS    = 21'h02212;
    localparam logic [20:0] CP_NBSP     = 21'h000A0;
    localparam logic [20:0] CP_SP_LO    = 21'h02002;
    localparam logic [20:0] CP_SP_HI    = 21'h0200A;
    localparam logic [20:0] CP_NNBSP    = 21'h0202F;
    localparam logic [20:0] CP_MMSP     = 21'h0205F;
    localparam logic [20:0] CP_IDSP     = 21'h03000;

    // Continuation bytes a lead byte calls for; 0 for anything else.
    function automatic logic [1:0] lead_len(input logic [7:0] b);
        logic [1:0] n;
        n = 2'd0;
        if (b[7:5] == 3'b110) begin
            n = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            n = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
            n = 2'd3;
        end
        return n;
    endfunction

    // {hit, code}
    function automatic logic [3:0] ws_code(input logic [7:0] b);
        logic [3:0] r;
        case (b)
            CH_SPACE: r = {1'b1, WS_SPACE};
            CH_TAB:   r = {1'b1, WS_TAB};
            CH_CR:    r = {1'b1, WS_CR};
            CH_FF:    r = {1'b1, WS_FF};
            CH_VT:    r = {1'b1, WS_VT};
            default:  r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] ws_byte(input logic [2:0] code);
        logic [7:0] r;
        case (code)
            WS_TAB:  r = CH_TAB;
            WS_CR:   r = CH_CR;
            WS_FF:   r = CH_FF;
            WS_VT:   r = CH_VT;
            default: r = CH_SPACE;
        endcase
        return r;
    endfunction

    // {hit, ascii}
    function automatic logic [8:0] fold(input logic [20:0] cp);
        logic [8:0] r;
        r = 9'd0;
        if (cp inside {[CP_SQ_LO:CP_SQ_HI]}) begin
            r = {1'b1, CH_QUOTE};
        end else if (cp inside {[CP_DQ_LO:CP_DQ_HI]}) begin
            r = {1'b1, CH_DQUOTE};
        end else if (cp inside {[CP_DASH_LO:CP_DASH_HI], CP_MINUS}) begin
            r = {1'b1, CH_HYPHEN};
        end else if (cp inside {CP_NBSP, [CP_SP_LO:CP_SP_HI], CP_NNBSP, CP_MMSP,
                                CP_IDSP}) begin
            r = {1'b1, CH_SPACE};
        end
        return r;
    endfunction

endpackage

### hdl/u8ws_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module u8ws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [AW-1:0]          i_waddr,
    input  logic [WIDTH-1:0]       i_wdata,
    input  logic [AW-1:0]          i_raddr,
    output logic [WIDTH-1:0]       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/u8ws_front.sv
// Decoder front: UTF-8 sequence tracking and folding, turns each input beat
// into zero to four strip operations. Depends on u8ws_pkg.
module u8ws_front import u8ws_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_eot,
    output logic       o_op_valid,
    input  logic       i_op_ready,
    output t_op        o_op
);
    logic [7:0] r_seq [3];
    logic [1:0] r_cnt, r_exp;
    logic [7:0] r_buf [4];
    logic [2:0] r_left;
    logic [1:0] r_pos;
    logic       r_end;

    logic [7:0]  ops [4];
    logic [7:0]  s_new [3];
    logic [1:0]  c_new, e_new, b_lead;
    logic [2:0]  n_pre, n_tot;
    logic [20:0] cp;
    logic [8:0]  fh;
    logic        is_cont, do_start, accept, push;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ops[i]   = r_seq[i];
            s_new[i] = r_seq[i];
        end
        ops[3]   = i_byte;
        c_new    = r_cnt;
        e_new    = r_exp;
        n_pre    = 3'd0;
        do_start = 1'b0;
        b_lead   = lead_len(i_byte);
        is_cont  = (i_byte[7:6] == 2'b10);
        case (r_exp)
            2'd1:    cp = {10'd0, r_seq[0][4:0], i_byte[5:0]};
            2'd2:    cp = {5'd0, r_seq[0][3:0], r_seq[1][5:0], i_byte[5:0]};
            2'd3:    cp = {r_seq[0][2:0], r_seq[1][5:0], r_seq[2][5:0], i_byte[5:0]};
            default: cp = 21'd0;
        endcase
        fh = fold(cp);

        if (r_exp == 2'd0) begin
            do_start = 1'b1;
        end else if (!is_cont) begin
            // broken sequence: stored bytes go out raw first
            n_pre    = {1'b0, r_cnt};
            c_new    = 2'd0;
            e_new    = 2'd0;
            do_start = 1'b1;
        end else if (r_cnt >= r_exp) begin
            c_new = 2'd0;
            e_new = 2'd0;
            if (fh[8]) begin
                ops[0] = fh[7:0];
                n_pre  = 3'd1;
            end else begin
                for (int i = 0; i < 4; i++) begin
                    if (3'(i) == {1'b0, r_cnt}) ops[i] = i_byte;
                end
                n_pre = {1'b0, r_cnt} + 3'd1;
            end
        end else begin
            for (int j = 0; j < 3; j++) begin
                if (2'(j) == r_cnt) s_new[j] = i_byte;
            end
            c_new = r_cnt + 2'd1;
        end

        if (do_start) begin
            if (b_lead != 2'd0) begin
                s_new[0] = i_byte;
                c_new    = 2'd1;
                e_new    = b_lead;
            end else begin
                for (int i = 0; i < 4; i++) begin
                    if (3'(i) == n_pre) ops[i] = i_byte;
                end
                n_pre = n_pre + 3'd1;
            end
        end

        n_tot = n_pre;
        if (i_eot && e_new != 2'd0) begin
            // cut-short sequence at the end of the text
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 3; j++) begin
                    if (2'(j) < c_new && 3'(i) == n_pre + 3'(j)) ops[i] = s_new[j];
                end
            end
            n_tot = n_pre + {1'b0, c_new};
            c_new = 2'd0;
            e_new = 2'd0;
        end
    end

    assign o_op_valid = (r_left != 3'd0);
    assign o_ready    = (r_left == 3'd0) || (r_left == 3'd1 && i_op_ready);
    assign accept     = i_valid && o_ready;
    assign push       = o_op_valid && i_op_ready;

    assign o_op.data = r_buf[r_pos];
    assign o_op.last = (r_left == 3'd1);
    assign o_op.eot  = r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_exp  <= 2'd0;
            r_left <= 3'd0;
            r_pos  <= 2'd0;
            r_end  <= 1'b0;
        end else if (accept) begin
            r_cnt  <= c_new;
            r_exp  <= e_new;
            r_left <= n_tot;
            r_pos  <= 2'd0;
            r_end  <= i_eot;
        end else if (push) begin
            r_left <= r_left - 3'd1;
            r_pos  <= r_pos + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_seq <= s_new;
            r_buf <= ops;
        end
    end
endmodule

### hdl/u8ws_queue.sv
// Small flop-based FIFO of strip operations between decoder and strip stage.
// Depends on u8ws_pkg.
module u8ws_queue import u8ws_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_data,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_op  o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_op           r_mem [DEPTH];
    logic [AW-1:0] r_rd, r_wr;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_ready = (r_cnt != FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            if (do_pop)  r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end
endmodule

### hdl/u8ws_back.sv
// Strip stage: holds whitespace in a ring RAM, drops it before a newline or
// at the end of the text, frames results. Depends on u8ws_pkg, u8ws_ram.
module u8ws_back import u8ws_pkg::*; #(
    parameter int WS_HOLD_DEPTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_op_valid,
    input  t_op  i_op,
    output logic o_op_pop,
    output logic o_res_valid,
    input  logic i_res_ready,
    output t_res o_res
);
    localparam int PTR_W = (WS_HOLD_DEPTH > 1) ? $clog2(WS_HOLD_DEPTH) : 1;
    localparam int CNT_W = $clog2(WS_HOLD_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WS_HOLD_DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(WS_HOLD_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(WS_HOLD_DEPTH - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DRAIN = 2'd1;
    localparam logic [1:0] S_OVF   = 2'd2;
    localparam logic [1:0] S_BYTE  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [PTR_W-1:0] r_head, n_head, head_inc, wr_tail;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [SUM_W-1:0] tail_sum, tail_mod;
    t_op              r_op, n_op, cur_op;
    logic             r_any, r_pend_v, r_out_v;
    t_res             r_pend, r_out, n_pend, new_res;

    logic             can_push, emit, emit_all, mark, fin, fin_eot, push, pop;
    logic [7:0]       e_byte;
    logic             e_ovf;
    logic             ram_we;
    logic [PTR_W-1:0] ram_waddr;
    logic [2:0]       ram_wdata, ram_rdata;
    logic [3:0]       cur_ws;

    assign can_push = !r_out_v || i_res_ready;
    assign tail_sum = SUM_W'(r_head) + SUM_W'(r_cnt);
    assign tail_mod = (tail_sum >= DEPTH_S) ? tail_sum - DEPTH_S : tail_sum;
    assign wr_tail  = tail_mod[PTR_W-1:0];
    assign head_inc = (r_head == LAST_PTR) ? '0 : r_head + 1'b1;
    assign cur_op   = (r_state == S_IDLE) ? i_op : r_op;
    assign cur_ws   = ws_code(cur_op.data);

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_cnt     = r_cnt;
        n_op      = r_op;
        pop       = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = wr_tail;
        ram_wdata = cur_ws[2:0];
        emit      = 1'b0;
        e_byte    = cur_op.data;
        e_ovf     = 1'b0;
        fin       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_op_valid && can_push) begin
                    pop  = 1'b1;
                    n_op = i_op;
                    if (cur_ws[3]) begin
                        if (r_cnt == FULL_CNT) begin
                            n_state = S_OVF;
                        end else begin
                            ram_we = 1'b1;
                            n_cnt  = r_cnt + 1'b1;
                            fin    = i_op.last;
                        end
                    end else if (i_op.data == CH_NEWLINE) begin
                        emit   = 1'b1;
                        n_head = '0;
                        n_cnt  = '0;
                        fin    = i_op.last;
                    end else if (r_cnt != '0) begin
                        n_state = S_DRAIN;
                    end else begin
                        emit   = 1'b1;
                        n_head = '0;
                        fin    = i_op.last;
                    end
                end
            end
            S_OVF: begin
                // oldest entry leaves flagged; the new code takes its slot
                if (can_push) begin
                    emit      = 1'b1;
                    e_byte    = ws_byte(ram_rdata);
                    e_ovf     = 1'b1;
                    ram_we    = 1'b1;
                    ram_waddr = r_head;
                    n_head    = head_inc;
                    fin       = r_op.last;
                    n_state   = S_IDLE;
                end
            end
            S_DRAIN: begin
                if (can_push) begin
                    emit   = 1'b1;
                    e_byte = ws_byte(ram_rdata);
                    n_head = head_inc;
                    n_cnt  = r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) n_state = S_BYTE;
                end
            end
            S_BYTE: begin
                if (can_push) begin
                    emit    = 1'b1;
                    n_head  = '0;
                    fin     = r_op.last;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        fin_eot = fin && cur_op.eot;
        if (fin_eot) begin
            n_head = '0;
            n_cnt  = '0;
        end
        // end marker when the closing beat produced nothing
        mark     = fin_eot && !emit && !r_any;
        emit_all = emit || mark;

        new_res.data = mark ? 8'd0 : e_byte;
        new_res.vld  = !mark;
        new_res.last = fin;
        new_res.done = fin_eot;
        new_res.ovf  = e_ovf;

        push = can_push && r_pend_v && (emit_all || r_pend.last);

        n_pend = r_pend;
        if (emit_all) begin
            n_pend = new_res;
        end else if (fin && r_any) begin
            n_pend.last = 1'b1;
            n_pend.done = fin_eot;
        end
    end

    u8ws_ram #(
        .WIDTH (3),
        .DEPTH (WS_HOLD_DEPTH)
    ) u_hold (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (n_head),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_cnt    <= '0;
            r_any    <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_cnt   <= n_cnt;
            if (fin)       r_any <= 1'b0;
            else if (emit) r_any <= 1'b1;
            if (emit_all)  r_pend_v <= 1'b1;
            else if (push) r_pend_v <= 1'b0;
            if (push)             r_out_v <= 1'b1;
            else if (i_res_ready) r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_pend <= n_pend;
        if (push) r_out <= r_pend;
    end

    assign o_op_pop    = pop;
    assign o_res_valid = r_out_v;
    assign o_res       = r_out;
endmodule

### hdl/utf8_fold_trailing_ws_normalizer_core.sv
// Top level of the UTF-8 punctuation fold and trailing whitespace strip.
// Depends on u8ws_pkg, u8ws_front, u8ws_queue, u8ws_back, assert_macros.svh.
//
//  channel  dir  tdata          tlast         tuser
//  s_axis   in   in_byte        end_of_input  -
//  m_axis   out  out_byte       run_last      byte_valid, text_done, hold_overflow
//
// Flow: the decoder takes one beat per cycle while it yields at most one operation
// and the queue has room; a broken or cut-short sequence holds it until each raw
// byte has gone out. The strip stage handles one operation at a time, drains held
// whitespace bytes from the hold RAM one by one, then sends the byte that follows a
// drain, and spends an extra step on hold overflow; the single read port of the hold RAM sets that pace.
// Reset is synchronous, active low; hold RAM content is not cleared, only its
// count. A stalled m_axis stops the strip stage; the 4-entry operation queue
// lets the decoder run ahead until it fills.
`include "assert_macros.svh"

module utf8_fold_trailing_ws_normalizer_core import u8ws_pkg::*; #(
    parameter int WS_HOLD_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,
    output logic [2:0] m_axis_tuser    // [0] byte_valid, [1] text_done, [2] hold_overflow
);
    t_op  fr_op, q_op;
    logic fr_op_valid, q_ready, q_valid, q_pop;
    t_res res;

    u8ws_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_byte     (s_axis_tdata),
        .i_eot      (s_axis_tlast),
        .o_op_valid (fr_op_valid),
        .i_op_ready (q_ready),
        .o_op       (fr_op)
    );

    u8ws_queue #(
        .DEPTH (4)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_op_valid),
        .i_data  (fr_op),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_op)
    );

    u8ws_back #(
        .WS_HOLD_DEPTH (WS_HOLD_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (q_valid),
        .i_op        (q_op),
        .o_op_pop    (q_pop),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    assign m_axis_tdata = res.data;
    assign m_axis_tlast = res.last;
    assign m_axis_tuser = {res.ovf, res.done, res.vld};

    // end marker only ever closes a text
    `U8WS_AST_IMP(a_marker_closes, i_clk, i_rst_n, m_axis_tvalid && !res.vld, res.last && res.done)
    // text end is always the last beat of its input
    `U8WS_AST_IMP(a_done_is_last, i_clk, i_rst_n, m_axis_tvalid && res.done, res.last)
    // an overflow beat always carries a byte
    `U8WS_AST_IMP(a_ovf_has_byte, i_clk, i_rst_n, m_axis_tvalid && res.ovf, res.vld)
    // decoder keeps its operation offered while the queue is full
    `U8WS_AST_NXT(a_op_held, i_clk, i_rst_n, fr_op_valid && !q_ready, fr_op_valid)
endmodule
